[src/path_guide_point_decimator_top_macros.svh]
// ----------------------------------------------------------------------------
// Path guide point decimator assertion macros
// Shared concurrent assertion forms for the decimator RTL.
// ----------------------------------------------------------------------------
`ifndef PATH_GUIDE_POINT_DECIMATOR_TOP_MACROS_SVH
`define PATH_GUIDE_POINT_DECIMATOR_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define PGPD_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define PGPD_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/pgpd_pkg.sv]
// ----------------------------------------------------------------------------
// pgpd_pkg
// Types and constants shared by the guide point decimator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pgpd_pkg;

  localparam int unsigned CFG_W          = 16;
  localparam int unsigned HEAD_W         = 16;
  localparam int unsigned DIST_W         = 16;
  localparam int unsigned CFG_IDX_W      = 1;
  localparam int unsigned PRESCALE_SHIFT = 24;
  localparam int unsigned ANGLE_ACC_W    = 32;
  localparam int unsigned TABLE_LEN      = 24;
  localparam int unsigned TAB_IDX_W      = 5;

  localparam logic [CFG_IDX_W-1:0] REG_SPACING = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TURN    = 1'd1;

  localparam logic [CFG_W-1:0] MIN_SPACING = 16'd100;
  localparam logic [CFG_W-1:0] MIN_TURN    = 16'd91;

  localparam logic [ANGLE_ACC_W-1:0] Z_HALF = 32'h8000_0000;

  // atan(2^-i) in 2pi/2^32 units
  localparam logic [ANGLE_ACC_W-1:0] ATAN_TAB [TABLE_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

  typedef struct packed {
    logic cap_in;
    logic cordic_start;
    logic pend_from_in;
    logic kept_from_in;
    logic kept_from_pend;
    logic before_from_angle;
    logic out_load;
    logic out_sel_pend;
  } pgpd_cmd_t;

  typedef struct packed {
    logic in_fin;
    logic cordic_done;
    logic keep;
    logic out_free;
  } pgpd_sts_t;

endpackage

`default_nettype wire

[src/pgpd_cordic.sv]
// ----------------------------------------------------------------------------
// pgpd_cordic
// Iterative vectoring CORDIC atan2, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pgpd_cordic import pgpd_pkg::*; #(
  parameter int unsigned COORD_WIDTH  = 24,
  parameter int unsigned ANGLE_WIDTH  = 16,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic signed [COORD_WIDTH:0]   dx_i,
  input  wire logic signed [COORD_WIDTH:0]   dy_i,
  output logic                               done_o,
  output logic             [ANGLE_WIDTH-1:0] angle_o
);

  localparam int unsigned XW     = COORD_WIDTH + 1 + PRESCALE_SHIFT + 2;
  localparam int unsigned GUARD  = XW - COORD_WIDTH - 1 - PRESCALE_SHIFT;
  localparam int unsigned STEP_W = $clog2(CORDIC_STEPS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);
  localparam logic [ANGLE_ACC_W-1:0] RND =
    ANGLE_ACC_W'(64'd1 << (ANGLE_ACC_W - 1 - ANGLE_WIDTH));

  typedef enum logic [1:0] {
    CD_IDLE,
    CD_PREP,
    CD_ITER,
    CD_ROUND
  } cd_state_e;

  cd_state_e                 state_q;
  logic signed [XW-1:0]      x_q, y_q;
  logic [ANGLE_ACC_W-1:0]    z_q;
  logic [STEP_W-1:0]         step_q;
  logic                      zero_q;
  logic                      done_q;
  logic [ANGLE_WIDTH-1:0]    angle_q;

  logic signed [XW-1:0]      x_sh, y_sh, x_it, y_it;
  logic [ANGLE_ACC_W-1:0]    tab, z_it, z_rnd;

  always_comb begin
    x_sh  = x_q >>> step_q;
    y_sh  = y_q >>> step_q;
    tab   = ATAN_TAB[TAB_IDX_W'(step_q)];
    z_rnd = z_q + RND;
    if (!y_q[XW-1]) begin
      x_it = x_q + y_sh;
      y_it = y_q - x_sh;
      z_it = z_q + tab;
    end else begin
      x_it = x_q - y_sh;
      y_it = y_q + x_sh;
      z_it = z_q - tab;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CD_IDLE;
      x_q     <= '0;
      y_q     <= '0;
      z_q     <= '0;
      step_q  <= '0;
      zero_q  <= 1'b0;
      done_q  <= 1'b0;
      angle_q <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        CD_IDLE: begin
          if (start_i) begin
            x_q     <= {{GUARD{dx_i[COORD_WIDTH]}}, dx_i, {PRESCALE_SHIFT{1'b0}}};
            y_q     <= {{GUARD{dy_i[COORD_WIDTH]}}, dy_i, {PRESCALE_SHIFT{1'b0}}};
            state_q <= CD_PREP;
          end
        end
        CD_PREP: begin
          zero_q <= (x_q == '0) && (y_q == '0);
          step_q <= '0;
          if (x_q[XW-1]) begin
            x_q <= -x_q;
            y_q <= -y_q;
            z_q <= Z_HALF;
          end else begin
            z_q <= '0;
          end
          state_q <= CD_ITER;
        end
        CD_ITER: begin
          x_q <= x_it;
          y_q <= y_it;
          z_q <= z_it;
          if (step_q == LAST_STEP) begin
            state_q <= CD_ROUND;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        CD_ROUND: begin
          angle_q <= zero_q ? '0 : z_rnd[ANGLE_ACC_W-1 -: ANGLE_WIDTH];
          done_q  <= 1'b1;
          state_q <= CD_IDLE;
        end
        default: begin
          state_q <= CD_IDLE;
        end
      endcase
    end
  end

  assign done_o  = done_q;
  assign angle_o = angle_q;

endmodule

`default_nettype wire

[src/pgpd_datapath.sv]
// ----------------------------------------------------------------------------
// pgpd_datapath
// Pose registers, config registers, turn and spacing tests, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pgpd_datapath import pgpd_pkg::*; #(
  parameter int unsigned COORD_WIDTH  = 24,
  parameter int unsigned ANGLE_WIDTH  = 16,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic        [CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic        [CFG_W-1:0]       cfg_wdata_i,
  input  wire logic signed [COORD_WIDTH-1:0] pos_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] pos_y_i,
  input  wire logic        [HEAD_W-1:0]      heading_i,
  input  wire logic                          final_pose_i,
  input  wire logic                          out_stall_i,
  output logic                               out_valid_o,
  output logic signed      [COORD_WIDTH-1:0] out_x_o,
  output logic signed      [COORD_WIDTH-1:0] out_y_o,
  output logic             [HEAD_W-1:0]      out_heading_o,
  output logic                               path_end_o,
  output logic                               run_last_o,
  input  wire pgpd_cmd_t                     cmd_i,
  output pgpd_sts_t                          sts_o
);

  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned SQ_W = 2 * DIST_W;
  localparam logic [ANGLE_WIDTH:0] FULL_TURN = {1'b1, {ANGLE_WIDTH{1'b0}}};

  logic [CW-1:0]          in_x_q, in_y_q, pend_x_q, pend_y_q, kept_x_q, kept_y_q;
  logic [HEAD_W-1:0]      in_h_q, pend_h_q;
  logic                   in_fin_q;
  logic [ANGLE_WIDTH-1:0] before_q;
  logic [CFG_W-1:0]       spacing_q, turn_q;

  logic [CW:0]            kdx_q, kdy_q, abs_x_q, abs_y_q;
  logic [SQ_W-1:0]        sqx_q, sqy_q, spsq_q;
  logic                   big_q, far_q;

  logic                   out_valid_q;
  logic [CW-1:0]          out_x_q, out_y_q;
  logic [HEAD_W-1:0]      out_h_q;
  logic                   out_end_q, out_last_q;

  logic signed [CW:0]     dx, dy;
  logic                   cd_done;
  logic [ANGLE_WIDTH-1:0] angle;
  logic [ANGLE_WIDTH-1:0] dang;
  logic [ANGLE_WIDTH:0]   mag;
  logic                   turn;
  logic                   out_free;

  assign dx = {in_x_q[CW-1], in_x_q} - {pend_x_q[CW-1], pend_x_q};
  assign dy = {in_y_q[CW-1], in_y_q} - {pend_y_q[CW-1], pend_y_q};

  pgpd_cordic #(
    .COORD_WIDTH  (COORD_WIDTH),
    .ANGLE_WIDTH  (ANGLE_WIDTH),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.cordic_start),
    .dx_i    (dx),
    .dy_i    (dy),
    .done_o  (cd_done),
    .angle_o (angle)
  );

  // wrapped heading change magnitude against threshold
  always_comb begin
    dang = angle - before_q;
    mag  = dang[ANGLE_WIDTH-1] ? (FULL_TURN - {1'b0, dang}) : {1'b0, dang};
    turn = {mag, {CFG_W{1'b0}}} >= {1'b0, turn_q, {ANGLE_WIDTH{1'b0}}};
  end

  assign out_free = !out_valid_q || !out_stall_i;

  assign sts_o.in_fin      = in_fin_q;
  assign sts_o.cordic_done = cd_done;
  assign sts_o.keep        = turn || far_q;
  assign sts_o.out_free    = out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spacing_q   <= MIN_SPACING;
      turn_q      <= MIN_TURN;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SPACING: spacing_q <= (cfg_wdata_i < MIN_SPACING) ? MIN_SPACING : cfg_wdata_i;
          REG_TURN:    turn_q    <= (cfg_wdata_i < MIN_TURN) ? MIN_TURN : cfg_wdata_i;
          default: ;
        endcase
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_in) begin
      in_x_q   <= pos_x_i;
      in_y_q   <= pos_y_i;
      in_h_q   <= heading_i;
      in_fin_q <= final_pose_i;
    end
    if (cmd_i.pend_from_in) begin
      pend_x_q <= in_x_q;
      pend_y_q <= in_y_q;
      pend_h_q <= in_h_q;
    end
    if (cmd_i.kept_from_in) begin
      kept_x_q <= in_x_q;
      kept_y_q <= in_y_q;
    end else if (cmd_i.kept_from_pend) begin
      kept_x_q <= pend_x_q;
      kept_y_q <= pend_y_q;
    end
    if (cmd_i.before_from_angle) begin
      before_q <= angle;
    end
    if (cmd_i.out_load) begin
      out_x_q    <= cmd_i.out_sel_pend ? pend_x_q : in_x_q;
      out_y_q    <= cmd_i.out_sel_pend ? pend_y_q : in_y_q;
      out_h_q    <= cmd_i.out_sel_pend ? pend_h_q : in_h_q;
      out_end_q  <= cmd_i.out_sel_pend ? 1'b0 : in_fin_q;
      out_last_q <= cmd_i.out_sel_pend ? !in_fin_q : 1'b1;
    end
    // spacing test pipeline, settles while the CORDIC runs
    kdx_q   <= {kept_x_q[CW-1], kept_x_q} - {pend_x_q[CW-1], pend_x_q};
    kdy_q   <= {kept_y_q[CW-1], kept_y_q} - {pend_y_q[CW-1], pend_y_q};
    abs_x_q <= kdx_q[CW] ? -kdx_q : kdx_q;
    abs_y_q <= kdy_q[CW] ? -kdy_q : kdy_q;
    big_q   <= (|abs_x_q[CW:DIST_W]) || (|abs_y_q[CW:DIST_W]);
    sqx_q   <= abs_x_q[DIST_W-1:0] * abs_x_q[DIST_W-1:0];
    sqy_q   <= abs_y_q[DIST_W-1:0] * abs_y_q[DIST_W-1:0];
    spsq_q  <= spacing_q * spacing_q;
    far_q   <= big_q || (({1'b0, sqx_q} + {1'b0, sqy_q}) >= {1'b0, spsq_q});
  end

  assign out_valid_o   = out_valid_q;
  assign out_x_o       = out_x_q;
  assign out_y_o       = out_y_q;
  assign out_heading_o = out_h_q;
  assign path_end_o    = out_end_q;
  assign run_last_o    = out_last_q;

endmodule

`default_nettype wire

[src/pgpd_ctrl.sv]
// ----------------------------------------------------------------------------
// pgpd_ctrl
// Sequencer: path position tracking, CORDIC launch, word emission order.
// ----------------------------------------------------------------------------
`default_nettype none
`include "path_guide_point_decimator_top_macros.svh"

module pgpd_ctrl import pgpd_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire pgpd_sts_t sts_i,
  output pgpd_cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CALC,
    ST_EMIT_PEND,
    ST_EMIT_IN
  } state_e;

  typedef enum logic [1:0] {
    SEEN_NONE,
    SEEN_FIRST,
    SEEN_HELD
  } seen_e;

  state_e state_q, state_d;
  seen_e  seen_q, seen_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    seen_d  = seen_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cap_in = 1'b1;
          state_d      = ST_LOAD;
        end
      end
      ST_LOAD: begin
        case (seen_q)
          SEEN_NONE: begin
            state_d = ST_EMIT_IN;
          end
          SEEN_FIRST: begin
            if (sts_i.in_fin) begin
              state_d = ST_EMIT_IN;
            end else begin
              cmd_o.cordic_start = 1'b1;
              state_d            = ST_CALC;
            end
          end
          default: begin
            cmd_o.cordic_start = 1'b1;
            state_d            = ST_CALC;
          end
        endcase
      end
      ST_CALC: begin
        if (sts_i.cordic_done) begin
          if (seen_q == SEEN_FIRST) begin
            cmd_o.before_from_angle = 1'b1;
            cmd_o.pend_from_in      = 1'b1;
            seen_d                  = SEEN_HELD;
            state_d                 = ST_IDLE;
          end else if (sts_i.keep) begin
            state_d = ST_EMIT_PEND;
          end else if (sts_i.in_fin) begin
            state_d = ST_EMIT_IN;
          end else begin
            cmd_o.before_from_angle = 1'b1;
            cmd_o.pend_from_in      = 1'b1;
            state_d                 = ST_IDLE;
          end
        end
      end
      ST_EMIT_PEND: begin
        if (sts_i.out_free) begin
          cmd_o.out_load       = 1'b1;
          cmd_o.out_sel_pend   = 1'b1;
          cmd_o.kept_from_pend = 1'b1;
          if (sts_i.in_fin) begin
            state_d = ST_EMIT_IN;
          end else begin
            cmd_o.before_from_angle = 1'b1;
            cmd_o.pend_from_in      = 1'b1;
            state_d                 = ST_IDLE;
          end
        end
      end
      ST_EMIT_IN: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (sts_i.in_fin) begin
            seen_d = SEEN_NONE;
          end else begin
            cmd_o.pend_from_in = 1'b1;
            cmd_o.kept_from_in = 1'b1;
            seen_d             = SEEN_FIRST;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      seen_q  <= SEEN_NONE;
    end else begin
      state_q <= state_d;
      seen_q  <= seen_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

  `PGPD_ASSERT_IMP(a_load_free, clk_i, rst_ni, cmd_o.out_load, sts_i.out_free, "output word loaded while slot busy")
  `PGPD_ASSERT_IMP(a_done_in_calc, clk_i, rst_ni, sts_i.cordic_done, state_q == ST_CALC, "CORDIC done outside wait state")
  `PGPD_ASSERT_NXT(a_no_fast_done, clk_i, rst_ni, cmd_o.cordic_start, !sts_i.cordic_done, "CORDIC done right after start")
  `PGPD_ASSERT_IMP(a_pend_not_final, clk_i, rst_ni, cmd_o.pend_from_in, !sts_i.in_fin, "final pose held as pending")

endmodule

`default_nettype wire

[src/path_guide_point_decimator_top.sv]
// ----------------------------------------------------------------------------
// path_guide_point_decimator_top
// Thins a stream of path poses to guide points. The first and final pose of
// each path are always passed on; a middle pose is passed on once its
// successor arrives, if the heading change across it reaches the turn
// threshold or it lies at least the spacing away from the last kept pose.
// Each pose yields zero, one or two output words; run_last marks the last
// word of a pose, path_end the last word of a path. One pose is processed at
// a time. A first pose, or a final pose following a first pose, skips the
// CORDIC and goes straight to output. Every other pose runs one atan2 on
// the shared iterative CORDIC, and any pose may also wait on a stalled
// output. The output register lets the next pose be taken while the last
// word still waits.
// Configuration: index 0 is spacing in mm, index 1 the turn threshold in
// 2pi/65536 units; values below 100 and 91 are raised to those minimums.
// Write them only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module path_guide_point_decimator_top import pgpd_pkg::*; #(
  parameter int unsigned COORD_WIDTH  = 24,
  parameter int unsigned ANGLE_WIDTH  = 16,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic        [CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic        [CFG_W-1:0]       cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic signed [COORD_WIDTH-1:0] pos_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] pos_y_i,
  input  wire logic        [HEAD_W-1:0]      heading_i,
  input  wire logic                          final_pose_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic signed      [COORD_WIDTH-1:0] out_x_o,
  output logic signed      [COORD_WIDTH-1:0] out_y_o,
  output logic             [HEAD_W-1:0]      out_heading_o,
  output logic                               path_end_o,
  output logic                               run_last_o
);

  pgpd_cmd_t cmd;
  pgpd_sts_t sts;

  pgpd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pgpd_datapath #(
    .COORD_WIDTH  (COORD_WIDTH),
    .ANGLE_WIDTH  (ANGLE_WIDTH),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .heading_i     (heading_i),
    .final_pose_i  (final_pose_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .out_x_o       (out_x_o),
    .out_y_o       (out_y_o),
    .out_heading_o (out_heading_o),
    .path_end_o    (path_end_o),
    .run_last_o    (run_last_o),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

endmodule

`default_nettype wire

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for path_guide_point_decimator_top. A short table of
// directed poses and register writes runs first, then random paths under
// several register settings and three idle patterns. Each accepted pose is
// run through a bit-exact model of the decimator, and every output word is
// compared field by field with the oldest predicted guide point.
// ----------------------------------------------------------------------------
`default_nettype none

module tb import pgpd_pkg::*; ();

  localparam int unsigned COORD_W  = 24;
  localparam int unsigned ANGLE_W  = 16;
  localparam int unsigned CORDIC_N = 16;
  localparam int unsigned SETTLE   = 64;
  localparam int unsigned SEG_LEN  = 325;
  localparam int          HOLD_LEN = 400;

  typedef enum logic {ROW_POSE, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e                  kind;
    logic [CFG_IDX_W-1:0]       idx;
    logic [CFG_W-1:0]           data;
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
    logic [HEAD_W-1:0]          h;
    logic                       fin;
    logic                       echo;
  } dir_row_t;

  typedef struct packed {
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
    logic [HEAD_W-1:0]          h;
    logic                       path_end;
    logic                       run_last;
  } guide_pt_t;

  // echo rows expect the pose itself back, path_end = fin, run_last = 1
  localparam int unsigned DIR_N = 25;
  localparam dir_row_t DIR_TAB [DIR_N] = '{
    '{ROW_POSE, REG_SPACING, 16'd0, 24'sd0, 24'sd0, 16'h0000, 1'b1, 1'b1},
    '{ROW_POSE, REG_SPACING, 16'd0, 24'h7FFFFF, 24'h800000, 16'hFFFF, 1'b1, 1'b1},
    '{ROW_POSE, REG_SPACING, 16'd0, 24'h800000, 24'h7FFFFF, 16'h0000, 1'b0, 1'b1},
    '{ROW_POSE, REG_SPACING, 16'd0, 24'h7FFFFF, 24'h800000, 16'hFFFF, 1'b1, 1'b1},
    '{ROW_POSE, REG_SPACING, 16'd0, 24'sd100, 24'sd100, 16'h0001, 1'b0, 1'b1},
    '{ROW_POSE, REG_SPACING, 16'd0, 24'sd100, 24'sd100, 16'h0002, 1'b0, 1'b0},
    '{ROW_POSE, REG_SPACING, 16'd0, 24'sd100, 24'sd100, 16'h0003, 1'b0, 1'b0},
    '{ROW_POSE, REG_SPACING, 16'd0, 24'sd300, 24'sd100, 16'h0004, 1'b1, 1'b0},
    '{ROW_POSE, REG_SPACING, 16'd0, 24'sd0, 24'sd0, 16'h1234, 1'b0, 1'b1},
    '{ROW_POSE, REG_SPACING, 16'd0, 24'sd10, 24'sd0, 16'h5555, 1'b0, 1'b0},
    '{ROW_POSE, REG_SPACING, 16'd0, 24'sd150, 24'sd0, 16'hAAAA, 1'b0, 1'b0},
    '{ROW_POSE, REG_SPACING, 16'd0, 24'sd160, 24'sd0, 16'h8000, 1'b0, 1'b0},
    '{ROW_POSE, REG_SPACING, 16'd0, 24'sd300, 24'sd0, 16'h7FFF, 1'b1, 1'b0},
    '{ROW_CFG,  REG_SPACING, 16'd0,     24'sd0, 24'sd0, 16'h0000, 1'b0, 1'b0},
    '{ROW_CFG,  REG_TURN,    16'd32768, 24'sd0, 24'sd0, 16'h0000, 1'b0, 1'b0},
    '{ROW_POSE, REG_SPACING, 16'd0, 24'sd0, 24'sd0, 16'h0100, 1'b0, 1'b1},
    '{ROW_POSE, REG_SPACING, 16'd0, 24'sd50, 24'sd0, 16'h0200, 1'b0, 1'b0},
    '{ROW_POSE, REG_SPACING, 16'd0, 24'sd0, 24'sd0, 16'h0300, 1'b0, 1'b0},
    '{ROW_POSE, REG_SPACING, 16'd0, 24'sd0, 24'sd50, 16'h0400, 1'b1, 1'b0},
    '{ROW_CFG,  REG_SPACING, 16'd65535, 24'sd0, 24'sd0, 16'h0000, 1'b0, 1'b0},
    '{ROW_CFG,  REG_TURN,    16'd65535, 24'sd0, 24'sd0, 16'h0000, 1'b0, 1'b0},
    '{ROW_POSE, REG_SPACING, 16'd0, 24'sd0, 24'sd0, 16'h0000, 1'b0, 1'b1},
    '{ROW_POSE, REG_SPACING, 16'd0, 24'sd1000, 24'sd0, 16'h4000, 1'b0, 1'b0},
    '{ROW_POSE, REG_SPACING, 16'd0, 24'sd1000, 24'sd1000, 16'hC000, 1'b0, 1'b0},
    '{ROW_POSE, REG_SPACING, 16'd0, 24'h800000, 24'h7FFFFF, 16'hFFFF, 1'b1, 1'b0}
  };

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_idx = '0;
  logic [CFG_W-1:0]          cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic signed [COORD_W-1:0] pos_x = '0;
  logic signed [COORD_W-1:0] pos_y = '0;
  logic [HEAD_W-1:0]         heading = '0;
  logic                      final_pose = 1'b0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [COORD_W-1:0] out_x;
  logic signed [COORD_W-1:0] out_y;
  logic [HEAD_W-1:0]         out_heading;
  logic                      path_end;
  logic                      run_last;

  guide_pt_t want_points [$];
  int        errors = 0;
  int        items_sent = 0;
  int        tx_idle_pct = 25;
  int        rx_idle_pct = 69;
  int        rx_hold_left = 0;
  int        hold_asks = 0;

  // model state
  logic [1:0]                pv_seen = 2'd0;
  logic signed [COORD_W-1:0] pv_prior_x = '0, pv_prior_y = '0;
  logic signed [COORD_W-1:0] pv_pend_x = '0, pv_pend_y = '0;
  logic [HEAD_W-1:0]         pv_pend_h = '0;
  logic signed [COORD_W-1:0] pv_kept_x = '0, pv_kept_y = '0;
  logic [CFG_W-1:0]          pv_spacing = 16'd100;
  logic [CFG_W-1:0]          pv_turn = 16'd91;

  path_guide_point_decimator_top #(
    .COORD_WIDTH (COORD_W),
    .ANGLE_WIDTH (ANGLE_W),
    .CORDIC_STEPS(CORDIC_N)
  ) dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .pos_x_i      (pos_x),
    .pos_y_i      (pos_y),
    .heading_i    (heading),
    .final_pose_i (final_pose),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .out_x_o      (out_x),
    .out_y_o      (out_y),
    .out_heading_o(out_heading),
    .path_end_o   (path_end),
    .run_last_o   (run_last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #16_000_000;
    $display("path_guide_point_decimator_top test failed");
    $finish;
  end

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    $display("ERROR %s: got 0x%0h want 0x%0h", what, got, want);
    errors++;
  endtask

  task automatic queue_word(input guide_pt_t w);
    want_points = {want_points, w};
  endtask

  // vectoring CORDIC atan2, 2pi/2^16 units
  function automatic logic [ANGLE_W-1:0] bearing_of(input longint dy, input longint dx);
    longint            cx, cy, nx, ny;
    logic [ANGLE_ACC_W-1:0] z;
    if (dx == 0 && dy == 0) return '0;
    cx = dx <<< PRESCALE_SHIFT;
    cy = dy <<< PRESCALE_SHIFT;
    z  = '0;
    if (cx < 0) begin
      cx = -cx;
      cy = -cy;
      z  = Z_HALF;
    end
    for (int i = 0; i < CORDIC_N; i++) begin
      if (cy >= 0) begin
        nx = cx + (cy >>> i);
        ny = cy - (cx >>> i);
        z  = z + ATAN_TAB[i];
      end else begin
        nx = cx - (cy >>> i);
        ny = cy + (cx >>> i);
        z  = z - ATAN_TAB[i];
      end
      cx = nx;
      cy = ny;
    end
    z = z + (32'd1 << (31 - ANGLE_W));
    return z[ANGLE_ACC_W-1 -: ANGLE_W];
  endfunction

  function automatic logic sharp_turn(input logic [ANGLE_W-1:0] before_a,
                                      input logic [ANGLE_W-1:0] after_a);
    logic [ANGLE_W-1:0] d;
    int                 mag, thr;
    d   = after_a - before_a;
    mag = (d >= (1 << (ANGLE_W - 1))) ? (1 << ANGLE_W) - int'(d) : int'(d);
    thr = (pv_turn < MIN_TURN) ? int'(MIN_TURN) : int'(pv_turn);
    return mag >= thr;
  endfunction

  function automatic logic spaced_out(input longint dx, input longint dy);
    longint ux, uy, s;
    s  = (pv_spacing < MIN_SPACING) ? longint'(MIN_SPACING) : longint'(pv_spacing);
    ux = (dx < 0) ? -dx : dx;
    uy = (dy < 0) ? -dy : dy;
    if (ux >= 65536 || uy >= 65536) return 1'b1;
    return ux * ux + uy * uy >= s * s;
  endfunction

  function automatic void decimate_pose(input logic signed [COORD_W-1:0] x,
                                        input logic signed [COORD_W-1:0] y,
                                        input logic [HEAD_W-1:0] h, input logic fin,
                                        output int n, output guide_pt_t w0,
                                        output guide_pt_t w1);
    logic [ANGLE_W-1:0] a_before, a_after;
    n  = 0;
    w0 = '0;
    w1 = '0;
    if (pv_seen == 2'd0) begin
      w0 = '{x, y, h, fin, 1'b0};
      n  = 1;
      if (!fin) begin
        pv_pend_x = x; pv_pend_y = y; pv_pend_h = h;
        pv_kept_x = x; pv_kept_y = y;
        pv_seen   = 2'd1;
      end
    end else if (pv_seen == 2'd1) begin
      if (fin) begin
        w0      = '{x, y, h, 1'b1, 1'b0};
        n       = 1;
        pv_seen = 2'd0;
      end else begin
        pv_prior_x = pv_pend_x; pv_prior_y = pv_pend_y;
        pv_pend_x  = x; pv_pend_y = y; pv_pend_h = h;
        pv_seen    = 2'd2;
      end
    end else begin
      a_before = bearing_of(longint'(pv_pend_y) - longint'(pv_prior_y),
                            longint'(pv_pend_x) - longint'(pv_prior_x));
      a_after  = bearing_of(longint'(y) - longint'(pv_pend_y),
                            longint'(x) - longint'(pv_pend_x));
      if (sharp_turn(a_before, a_after) ||
          spaced_out(longint'(pv_kept_x) - longint'(pv_pend_x),
                     longint'(pv_kept_y) - longint'(pv_pend_y))) begin
        w0 = '{pv_pend_x, pv_pend_y, pv_pend_h, 1'b0, 1'b0};
        n  = 1;
        pv_kept_x = pv_pend_x; pv_kept_y = pv_pend_y;
      end
      if (fin) begin
        if (n == 0) w0 = '{x, y, h, 1'b1, 1'b0};
        else        w1 = '{x, y, h, 1'b1, 1'b0};
        n++;
        pv_seen = 2'd0;
      end else begin
        pv_prior_x = pv_pend_x; pv_prior_y = pv_pend_y;
        pv_pend_x  = x; pv_pend_y = y; pv_pend_h = h;
      end
    end
    if (n == 1) w0.run_last = 1'b1;
    if (n == 2) w1.run_last = 1'b1;
  endfunction

  // returns right after the edge at which the word was taken
  task automatic drive_pose(input logic signed [COORD_W-1:0] x,
                            input logic signed [COORD_W-1:0] y,
                            input logic [HEAD_W-1:0] h, input logic fin, input logic echo);
    int        n;
    guide_pt_t w0, w1;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    pos_x      <= x;
    pos_y      <= y;
    heading    <= h;
    final_pose <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    decimate_pose(x, y, h, fin, n, w0, w1);
    if (echo) begin
      queue_word('{x, y, h, fin, 1'b1});
    end else begin
      if (n > 0) queue_word(w0);
      if (n > 1) queue_word(w1);
    end
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (want_points.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    wait_drain();
    repeat (SETTLE) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_SPACING) pv_spacing = data;
    else                    pv_turn    = data;
  endtask

  // random walk path; a few jumps and early ends break the pattern
  task automatic run_path();
    int                        len, pick, sc, bx, by, sx, sy;
    logic signed [COORD_W-1:0] px, py;
    logic                      fin;
    pick = $urandom_range(99);
    if (pick < 10)      len = 1;
    else if (pick < 20) len = 2;
    else if (pick < 90) len = $urandom_range(12, 3);
    else                len = $urandom_range(40, 13);
    pick = $urandom_range(99);
    if (pick < 40)      sc = 150;
    else if (pick < 70) sc = 3000;
    else if (pick < 90) sc = 70000;
    else                sc = 8388607;
    px = COORD_W'($urandom);
    py = COORD_W'($urandom);
    bx = int'($urandom_range(2 * sc)) - sc;
    by = int'($urandom_range(2 * sc)) - sc;
    for (int k = 0; k < len; k++) begin
      if (k > 0) begin
        pick = $urandom_range(99);
        if (pick < 8) begin
          sx = 0; sy = 0;
        end else if (pick < 45) begin
          sx = bx; sy = by;
        end else if (pick < 70) begin
          bx = bx + int'($urandom_range(16)) - 8;
          by = by + int'($urandom_range(16)) - 8;
          sx = bx; sy = by;
        end else begin
          bx = int'($urandom_range(2 * sc)) - sc;
          by = int'($urandom_range(2 * sc)) - sc;
          sx = bx; sy = by;
        end
        px = COORD_W'(px + sx);
        py = COORD_W'(py + sy);
        if ($urandom_range(99) < 4) begin
          px = COORD_W'($urandom);
          py = COORD_W'($urandom);
        end
      end
      fin = (k == len - 1) || ($urandom_range(99) == 0);
      drive_pose(px, py, HEAD_W'($urandom_range(65535)), fin, 1'b0);
      if (fin) break;
    end
  endtask

  initial begin : rx_side
    guide_pt_t w;
    int        hold_seen;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (want_points.size() == 0) begin
          flag_mismatch("word without expectation, out_x", longint'(out_x), longint'(0));
        end else begin
          w = want_points.pop_front();
          if (out_x !== w.x)
            flag_mismatch("out_x", longint'(out_x), longint'(w.x));
          if (out_y !== w.y)
            flag_mismatch("out_y", longint'(out_y), longint'(w.y));
          if (out_heading !== w.h)
            flag_mismatch("out_heading", longint'(out_heading), longint'(w.h));
          if (path_end !== w.path_end)
            flag_mismatch("path_end", longint'(path_end), longint'(w.path_end));
          if (run_last !== w.run_last)
            flag_mismatch("run_last", longint'(run_last), longint'(w.run_last));
        end
      end
      if (hold_seen != hold_asks) begin
        hold_seen    = hold_asks;
        rx_hold_left = HOLD_LEN;
      end
      if (rx_hold_left > 0) begin
        out_stall <= 1'b1;
        rx_hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  initial begin : tx_side
    int  seg_start;
    logic held, paused;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < DIR_N; r++) begin
      if (DIR_TAB[r].kind == ROW_CFG) write_reg(DIR_TAB[r].idx, DIR_TAB[r].data);
      else drive_pose(DIR_TAB[r].x, DIR_TAB[r].y, DIR_TAB[r].h, DIR_TAB[r].fin,
                      DIR_TAB[r].echo);
    end

    for (int seg = 0; seg < 6; seg++) begin
      case (seg)
        0, 1:    begin tx_idle_pct = 25; rx_idle_pct = 69; end
        2, 3:    begin tx_idle_pct = 69; rx_idle_pct = 25; end
        default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
      endcase
      case (seg)
        0: begin
          write_reg(REG_SPACING, 16'd100);
          write_reg(REG_TURN, 16'd91);
        end
        1: begin
          write_reg(REG_SPACING, CFG_W'($urandom_range(3000, 100)));
          write_reg(REG_TURN, CFG_W'($urandom_range(6000, 91)));
        end
        2: begin
          write_reg(REG_SPACING, 16'd65535);
          write_reg(REG_TURN, 16'd32768);
        end
        3: begin
          write_reg(REG_SPACING, 16'd0);
          write_reg(REG_TURN, 16'd0);
        end
        4: begin
          write_reg(REG_SPACING, CFG_W'($urandom_range(2000)));
          write_reg(REG_TURN, 16'd65535);
        end
        default: begin
          write_reg(REG_SPACING, CFG_W'($urandom_range(65535)));
          write_reg(REG_TURN, CFG_W'($urandom_range(65535)));
        end
      endcase
      seg_start = items_sent;
      held      = 1'b0;
      paused    = 1'b0;
      while (items_sent - seg_start < SEG_LEN) begin
        run_path();
        if ((seg == 2 || seg == 4) && !held && items_sent - seg_start > SEG_LEN / 2) begin
          // long output hold-off while poses keep coming
          hold_asks++;
          held = 1'b1;
        end
        if (seg == 3 && !paused && items_sent - seg_start > SEG_LEN / 2) begin
          wait_drain();
          paused = 1'b1;
        end
      end
    end

    wait_drain();
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("path_guide_point_decimator_top test passed");
    end else begin
      $display("path_guide_point_decimator_top test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
